@@ hw/rtl/lagd_pkg.sv @@
// ----------------------------------------------------------------------------
// lagd_pkg
// Shared constants and types for the linear array gain pipeline.
// ----------------------------------------------------------------------------
package lagd_pkg;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [31:0] PHASE_QUARTER = 32'h4000_0000;

    // odd sine polynomial over a quarter turn, q30
    localparam logic [30:0] POLY_C1 = 31'd1686629713;
    localparam logic [30:0] POLY_C3 = 31'd693598668;
    localparam logic [30:0] POLY_C5 = 31'd85569306;
    localparam logic [30:0] POLY_C7 = 31'd5026991;
    localparam logic [30:0] POLY_C9 = 31'd172271;

    // 10*log10(2) in q24
    localparam logic [25:0] DB_PER_OCTAVE_Q24 = 26'd50504453;
    localparam logic [5:0]  LOG_OFFSET = 6'd46;

    localparam logic [1:0] CFG_ELEMENT_COUNT   = 2'd0;
    localparam logic [1:0] CFG_ELEMENT_SPACING = 2'd1;
    localparam logic [1:0] CFG_STEER_ANGLE     = 2'd2;

    typedef struct packed {
        logic ovf;
        logic peak;
    } div_side_t;

    typedef struct packed {
        logic [5:0] expo;
        logic       zero;
        logic       peak;
    } log_side_t;

endpackage

@@ hw/rtl/linear_array_gain_db_core.sv @@
// ----------------------------------------------------------------------------
// linear_array_gain_db_core
// Gain in dB of a steered uniform linear array for one look angle per beat.
// ----------------------------------------------------------------------------
// channel  dir  ports             beat contents
// s_       in   tvalid/tready     tdata[15:0] look_angle
// m_       out  tvalid/tready     tdata[15:0] gain_db, tuser[1:0] flags
// cfg_     in   we/idx/data       element_count, element_spacing, steer_angle
//
// one beat per cycle sustained while the output is not stalled; the depth is
// set by the bit-per-stage divider and the 16 squaring cells of the log2
// reset is synchronous, clears valid state and restores register defaults
// a stalled output holds; the pipeline keeps moving while it has a bubble
// ----------------------------------------------------------------------------
module linear_array_gain_db_core import lagd_pkg::*; #(
    parameter int MAX_ELEMENTS = 64,
    parameter int ANGLE_BITS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // look_angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // gain_db
    output logic [1:0]  m_tuser,   // zero_response, peak_limit
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [15:0] cfg_data
);

    localparam int NW   = $clog2(MAX_ELEMENTS + 1);
    localparam int QW   = NW + 16;
    localparam int RW   = QW + 31;
    localparam int PW   = QW + 31;
    localparam int GN   = (PW + 7) / 8;
    localparam int PPW  = GN * 8;
    localparam int GW   = $clog2(GN);
    localparam int LAT  = 37 + QW;
    localparam int ADLY = 9 + QW;

    logic [6:0]  count_reg;
    logic [15:0] spacing_reg;
    logic [15:0] steer_reg;
    logic [NW-1:0] n_eff;
    logic [QW-1:0] n_q16;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic m_tvalid_reg;
    logic [15:0] gain_reg;
    logic [1:0]  flag_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= 7'd4;
            spacing_reg <= 16'd2048;
            steer_reg   <= 16'd21845;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_ELEMENT_COUNT:   count_reg   <= cfg_data[6:0];
                CFG_ELEMENT_SPACING: spacing_reg <= cfg_data;
                CFG_STEER_ANGLE:     steer_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (count_reg == 7'd0) begin
            n_eff = NW'(1);
        end else if ({25'b0, count_reg} > MAX_ELEMENTS) begin
            n_eff = NW'(MAX_ELEMENTS);
        end else begin
            n_eff = NW'(count_reg);
        end
        n_q16 = {n_eff, 16'b0};
    end

    // flow control
    assign en       = !m_tvalid_reg || m_tready || !vld_reg[LAT-1];
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // cosines of look and steer angles
    logic [31:0] look32;
    logic [31:0] steer32;
    logic [31:0] look_ph;
    logic [31:0] steer_ph;
    logic signed [31:0] cos_b;
    logic signed [31:0] cos_s;

    always_comb begin
        look32   = {16'b0, s_tdata};
        steer32  = {16'b0, steer_reg};
        look_ph  = (look32 << (32 - ANGLE_BITS)) + PHASE_QUARTER;
        steer_ph = (steer32 << (32 - ANGLE_BITS)) + PHASE_QUARTER;
    end

    lagd_sine u_cos_look (.aclk(aclk), .en(en), .phase(look_ph), .sine(cos_b));
    lagd_sine u_cos_steer (.aclk(aclk), .en(en), .phase(steer_ph), .sine(cos_s));

    // phase difference times spacing
    logic signed [32:0] diff;
    logic signed [49:0] prod50;
    logic [42:0] prod_reg;
    logic [30:0] acb_reg [0:ADLY-1];

    always_comb begin
        diff   = {cos_b[31], cos_b} - {cos_s[31], cos_s};
        prod50 = diff * $signed({1'b0, spacing_reg});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= prod50[42:0];
            acb_reg[0] <= cos_b[31] ? 31'(-cos_b) : cos_b[30:0];
            for (int i = 1; i < ADLY; i++) begin
                acb_reg[i] <= acb_reg[i-1];
            end
        end
    end

    logic [42+NW:0] nfull;
    logic [31:0] half_reg;
    logic [31:0] nph_reg;

    assign nfull = {{NW{1'b0}}, prod_reg} * {43'b0, n_eff};

    always_ff @(posedge aclk) begin
        if (en) begin
            half_reg <= prod_reg[42:11];
            nph_reg  <= nfull[42:11];
        end
    end

    logic signed [31:0] den_s;
    logic signed [31:0] num_s;

    lagd_sine u_sin_den (.aclk(aclk), .en(en), .phase(half_reg), .sine(den_s));
    lagd_sine u_sin_num (.aclk(aclk), .en(en), .phase(nph_reg), .sine(num_s));

    // divider setup
    logic [30:0] an;
    logic [30:0] ad;
    logic [30+NW:0] ad_lim;
    logic [RW-1:0] rem_w [0:QW];
    logic [30:0]   dv_w  [0:QW];
    logic [QW-1:0] quo_w [0:QW];
    div_side_t     dsd_w [0:QW];
    logic [RW-1:0] rem0_reg;
    logic [30:0]   ad_reg;
    div_side_t     dsd_reg;

    always_comb begin
        an     = num_s[31] ? 31'(-num_s) : num_s[30:0];
        ad     = den_s[31] ? 31'(-den_s) : den_s[30:0];
        ad_lim = {{NW{1'b0}}, ad} << NW;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem0_reg     <= RW'({an, 16'b0});
            ad_reg       <= ad;
            dsd_reg.ovf  <= ({{NW{1'b0}}, an} >= ad_lim);
            dsd_reg.peak <= (ad == 31'd0);
        end
    end

    assign rem_w[0] = rem0_reg;
    assign dv_w[0]  = ad_reg;
    assign quo_w[0] = '0;
    assign dsd_w[0] = dsd_reg;

    for (genvar j = 0; j < QW; j++) begin : g_div
        lagd_div_cell #(.QW(QW), .RW(RW), .BIT(QW - 1 - j)) u_div (
            .aclk     (aclk),
            .en       (en),
            .rem_in   (rem_w[j]),
            .den_in   (dv_w[j]),
            .quo_in   (quo_w[j]),
            .side_in  (dsd_w[j]),
            .rem_out  (rem_w[j+1]),
            .den_out  (dv_w[j+1]),
            .quo_out  (quo_w[j+1]),
            .side_out (dsd_w[j+1])
        );
    end

    // ratio times |cos beta|
    logic [QW-1:0] ratio;
    logic [PW-1:0] p_reg;
    logic          peak_p_reg;

    always_comb begin
        if (dsd_w[QW].peak || dsd_w[QW].ovf || (quo_w[QW] > n_q16)) begin
            ratio = n_q16;
        end else begin
            ratio = quo_w[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg      <= {31'b0, ratio} * {{QW{1'b0}}, acb_reg[ADLY-1]};
            peak_p_reg <= dsd_w[QW].peak;
        end
    end

    // leading one search, byte then bit
    logic [PPW-1:0] p_pad;
    logic [GW-1:0]  grp;
    logic [PPW-1:0] p1_reg;
    logic [GW-1:0]  grp_reg;
    log_side_t      ls1_reg;

    always_comb begin
        p_pad = PPW'(p_reg);
        grp   = '0;
        for (int i = 0; i < GN; i++) begin
            if (p_pad[i*8 +: 8] != 8'd0) begin
                grp = GW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg       <= p_pad;
            grp_reg      <= grp;
            ls1_reg.expo <= '0;
            ls1_reg.zero <= (p_reg == '0);
            ls1_reg.peak <= peak_p_reg;
        end
    end

    logic [7:0] lead_byte;
    logic [2:0] lead_bit;
    logic [PPW-1:0] p2_reg;
    log_side_t      ls2_reg;

    always_comb begin
        lead_byte = p1_reg[grp_reg*8 +: 8];
        lead_bit  = '0;
        for (int i = 0; i < 8; i++) begin
            if (lead_byte[i]) begin
                lead_bit = 3'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_reg       <= p1_reg;
            ls2_reg.expo <= 6'({grp_reg, lead_bit});
            ls2_reg.zero <= ls1_reg.zero;
            ls2_reg.peak <= ls1_reg.peak;
        end
    end

    logic [30:0] mant;
    logic [30:0] m_w   [0:16];
    logic [15:0] fr_w  [0:16];
    log_side_t   lsd_w [0:16];
    logic [30:0] mant_reg;
    log_side_t   ls3_reg;

    always_comb begin
        if (ls2_reg.expo > 6'd30) begin
            mant = 31'(p2_reg >> (ls2_reg.expo - 6'd30));
        end else begin
            mant = 31'(p2_reg << (6'd30 - ls2_reg.expo));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mant_reg <= mant;
            ls3_reg  <= ls2_reg;
        end
    end

    assign m_w[0]   = mant_reg;
    assign fr_w[0]  = '0;
    assign lsd_w[0] = ls3_reg;

    for (genvar k = 0; k < 16; k++) begin : g_sqr
        lagd_sqr_cell u_sqr (
            .aclk     (aclk),
            .en       (en),
            .mant_in  (m_w[k]),
            .frac_in  (fr_w[k]),
            .side_in  (lsd_w[k]),
            .mant_out (m_w[k+1]),
            .frac_out (fr_w[k+1]),
            .side_out (lsd_w[k+1])
        );
    end

    // log2 to dB
    logic signed [23:0] l2;
    logic [22:0] al_reg;
    logic        neg_reg;
    log_side_t   ls4_reg;

    assign l2 = $signed({2'b0, lsd_w[16].expo, fr_w[16]})
              - $signed({2'b0, LOG_OFFSET, 16'b0});

    always_ff @(posedge aclk) begin
        if (en) begin
            al_reg  <= l2[23] ? 23'(-l2) : l2[22:0];
            neg_reg <= l2[23];
            ls4_reg <= lsd_w[16];
        end
    end

    logic [48:0] pm_reg;
    logic        neg5_reg;
    log_side_t   ls5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pm_reg   <= {26'b0, al_reg} * {23'b0, DB_PER_OCTAVE_Q24};
            neg5_reg <= neg_reg;
            ls5_reg  <= ls4_reg;
        end
    end

    logic [49:0] rsum;
    logic [17:0] mag;
    logic [15:0] gain_next;

    always_comb begin
        rsum = {1'b0, pm_reg} + 50'h0_8000_0000;
        mag  = rsum[49:32];
        if (ls5_reg.zero) begin
            gain_next = 16'h8000;
        end else if (neg5_reg) begin
            gain_next = (mag > 18'd32768) ? 16'h8000 : 16'(-mag);
        end else begin
            gain_next = (mag > 18'd32767) ? 16'h7FFF : mag[15:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            m_tvalid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_tvalid_reg || m_tready) begin
            gain_reg <= gain_next;
            flag_reg <= {ls5_reg.peak, ls5_reg.zero};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = gain_reg;
    assign m_tuser  = flag_reg;

    a_zero_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 16'h8000)
        else $error("zero response without minimum gain");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted beat lost at pipeline entry");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

endmodule

@@ hw/rtl/lagd_horner_cell.sv @@
// ----------------------------------------------------------------------------
// lagd_horner_cell
// One step of the sine polynomial: t_out = coef - x2*t_in, registered.
// ----------------------------------------------------------------------------
module lagd_horner_cell import lagd_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [30:0] coef,
    input  logic [1:0]  quad_in,
    input  logic [30:0] x_in,
    input  logic [30:0] x2_in,
    input  logic [30:0] t_in,
    output logic [1:0]  quad_out,
    output logic [30:0] x_out,
    output logic [30:0] x2_out,
    output logic [30:0] t_out
);

    logic [61:0] mul;
    logic [30:0] t_next;
    logic [1:0]  quad_reg;
    logic [30:0] x_reg;
    logic [30:0] x2_reg;
    logic [30:0] t_reg;

    always_comb begin
        mul    = {31'b0, x2_in} * {31'b0, t_in};
        t_next = coef - mul[60:30];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quad_reg <= quad_in;
            x_reg    <= x_in;
            x2_reg   <= x2_in;
            t_reg    <= t_next;
        end
    end

    assign quad_out = quad_reg;
    assign x_out    = x_reg;
    assign x2_out   = x2_reg;
    assign t_out    = t_reg;

endmodule

@@ hw/rtl/lagd_sine.sv @@
// ----------------------------------------------------------------------------
// lagd_sine
// Pipelined sine of a 32-bit turn fraction, signed q30, six stages.
// ----------------------------------------------------------------------------
module lagd_sine import lagd_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic [31:0]        phase,
    output logic signed [31:0] sine
);

    logic [30:0] x_in;
    logic [61:0] sq;
    logic [1:0]  quad_reg;
    logic [30:0] x_reg;
    logic [30:0] x2_reg;

    logic [1:0]  quad_w [0:4];
    logic [30:0] x_w    [0:4];
    logic [30:0] x2_w   [0:4];
    logic [30:0] t_w    [0:4];
    logic [30:0] coef_w [0:3];

    logic [61:0] fm;
    logic [31:0] s_raw;
    logic [30:0] s_mag;
    logic signed [31:0] sine_next;
    logic signed [31:0] sine_reg;

    always_comb begin
        x_in = phase[30] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
        sq   = {31'b0, x_in} * {31'b0, x_in};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quad_reg <= phase[31:30];
            x_reg    <= x_in;
            x2_reg   <= sq[60:30];
        end
    end

    assign quad_w[0] = quad_reg;
    assign x_w[0]    = x_reg;
    assign x2_w[0]   = x2_reg;
    assign t_w[0]    = POLY_C9;
    assign coef_w[0] = POLY_C7;
    assign coef_w[1] = POLY_C5;
    assign coef_w[2] = POLY_C3;
    assign coef_w[3] = POLY_C1;

    for (genvar i = 0; i < 4; i++) begin : g_cell
        lagd_horner_cell u_cell (
            .aclk     (aclk),
            .en       (en),
            .coef     (coef_w[i]),
            .quad_in  (quad_w[i]),
            .x_in     (x_w[i]),
            .x2_in    (x2_w[i]),
            .t_in     (t_w[i]),
            .quad_out (quad_w[i+1]),
            .x_out    (x_w[i+1]),
            .x2_out   (x2_w[i+1]),
            .t_out    (t_w[i+1])
        );
    end

    always_comb begin
        fm    = {31'b0, x_w[4]} * {31'b0, t_w[4]};
        s_raw = fm[61:30];
        s_mag = (s_raw > {1'b0, Q30_ONE}) ? Q30_ONE : s_raw[30:0];
        sine_next = quad_w[4][1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule

@@ hw/rtl/lagd_div_cell.sv @@
// ----------------------------------------------------------------------------
// lagd_div_cell
// One restoring division step producing quotient bit BIT.
// ----------------------------------------------------------------------------
module lagd_div_cell import lagd_pkg::*; #(
    parameter int QW  = 23,
    parameter int RW  = 54,
    parameter int BIT = 0
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [RW-1:0] rem_in,
    input  logic [30:0]   den_in,
    input  logic [QW-1:0] quo_in,
    input  div_side_t     side_in,
    output logic [RW-1:0] rem_out,
    output logic [30:0]   den_out,
    output logic [QW-1:0] quo_out,
    output div_side_t     side_out
);

    logic [RW-1:0] trial;
    logic [RW-1:0] rem_next;
    logic [QW-1:0] quo_next;
    logic [RW-1:0] rem_reg;
    logic [30:0]   den_reg;
    logic [QW-1:0] quo_reg;
    div_side_t     side_reg;

    always_comb begin
        trial    = RW'(den_in) << BIT;
        rem_next = rem_in;
        quo_next = quo_in;
        if (rem_in >= trial) begin
            rem_next      = rem_in - trial;
            quo_next[BIT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            den_reg  <= den_in;
            quo_reg  <= quo_next;
            side_reg <= side_in;
        end
    end

    assign rem_out  = rem_reg;
    assign den_out  = den_reg;
    assign quo_out  = quo_reg;
    assign side_out = side_reg;

endmodule

@@ hw/rtl/lagd_sqr_cell.sv @@
// ----------------------------------------------------------------------------
// lagd_sqr_cell
// One log2 fraction bit by squaring a normalised q30 mantissa.
// ----------------------------------------------------------------------------
module lagd_sqr_cell import lagd_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [30:0] mant_in,
    input  logic [15:0] frac_in,
    input  log_side_t   side_in,
    output logic [30:0] mant_out,
    output logic [15:0] frac_out,
    output log_side_t   side_out
);

    logic [61:0] mm;
    logic [31:0] sq;
    logic [30:0] mant_next;
    logic [30:0] mant_reg;
    logic [15:0] frac_reg;
    log_side_t   side_reg;

    always_comb begin
        mm        = {31'b0, mant_in} * {31'b0, mant_in};
        sq        = mm[61:30];
        mant_next = sq[31] ? sq[31:1] : sq[30:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mant_reg <= mant_next;
            frac_reg <= {frac_in[14:0], sq[31]};
            side_reg <= side_in;
        end
    end

    assign mant_out = mant_reg;
    assign frac_out = frac_reg;
    assign side_out = side_reg;

endmodule
